/* rtl/arpc_pkg.sv */
// Shared types and codes for the ARP responder with resolution cache.
// Holds the probe token that walks the cache cells and the result layout.
// No dependencies.
package arpc_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int CFG_ADDR_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_OWN_IP  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OWN_MAC = 8'd1;

    // ARP opcodes as seen on the wire and in the result
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;
    localparam logic [1:0]  FOP_NONE    = 2'd0;
    localparam logic [1:0]  FOP_REQUEST = 2'd1;
    localparam logic [1:0]  FOP_REPLY   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_NOT_US    = 3'd2;
    localparam logic [2:0] ST_BAD_OP    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // token kinds travelling down the cell row
    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

    // One token in the cell row. On a search, hit/mac/free collect what the
    // cells found. On a write, hit selects update-in-place versus fill of the
    // first free entry, and done marks that some cell already took it.
    typedef struct packed {
        logic             act;
        logic             kind;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             hit;
        logic             free;
        logic             done;
    } t_probe;

    // Result item, send_frame in the lowest bit.
    typedef struct packed {
        logic [2:0]       status;
        logic [MAC_W-1:0] lookup_mac;
        logic             lookup_hit;
        logic [IP_W-1:0]  frame_tgt_ip;
        logic [MAC_W-1:0] frame_target_mac;
        logic [MAC_W-1:0] frame_dest_mac;
        logic [1:0]       frame_opcode;
        logic             send_frame;
    } t_result;

endpackage

/* rtl/arpc_cell.sv */
// One cache entry (IP, MAC, valid) with its stage of the probe row.
// Depends on arpc_pkg for the probe token type.
module arpc_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  arpc_pkg::t_probe i_probe,
    output arpc_pkg::t_probe o_probe
);

    logic                       r_valid;
    logic [arpc_pkg::IP_W-1:0]  r_ip;
    logic [arpc_pkg::MAC_W-1:0] r_mac;
    arpc_pkg::t_probe           r_probe;
    arpc_pkg::t_probe           n_probe;
    logic                       w_match;
    logic                       w_take;

    assign w_match = r_valid && (r_ip == i_probe.ip);
    // a write goes to the first matching entry, or to the first free one
    assign w_take  = i_probe.act && (i_probe.kind == arpc_pkg::KIND_WRITE) && !i_probe.done
                     && (i_probe.hit ? w_match : !r_valid);

    always_comb begin
        n_probe = i_probe;
        if (i_probe.act && (i_probe.kind == arpc_pkg::KIND_SEARCH)) begin
            if (w_match && !i_probe.hit) begin
                n_probe.hit = 1'b1;
                n_probe.mac = r_mac;
            end
            if (!r_valid) begin
                n_probe.free = 1'b1;
            end
        end
        if (w_take) begin
            n_probe.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_probe.act <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (w_take) begin
                r_valid <= 1'b1;
            end
        end
        if (w_take) begin
            r_ip  <= i_probe.ip;
            r_mac <= i_probe.mac;
        end
    end

    assign o_probe = r_probe;

endmodule

/* rtl/arp_responder_with_cache.sv */
// Top level of the ARP responder with a resolution cache.
// Depends on arpc_pkg and arpc_cell (one cell per cache entry).
//
// Usage:
//   Slave stream: one request per beat. tuser = req_type (0 received ARP
//   packet, 1 lookup of an IP). tdata carries the parsed packet fields and
//   the query address. Master stream: exactly one result per request.
//   Configuration channel: write own_ip (index 0) or own_mac (index 1)
//   while no request is in flight; it is always ready.
// Flow:
//   A packet dropped for length, target or opcode has its result written
//   straight into the output register, or into the hold register on a stall.
//   Lookups and accepted packets send a search token through the row of
//   ENTRIES cells, one cell per cycle, and the result is built from the
//   token that leaves the last cell. One request is handled at a time.
//   A cache write token follows the search down the row; later searches
//   trail it, so they always see the updated entry.
// Reset: clears all valid bits, own_ip and own_mac, and any tokens in flight.
// Stall: a finished result waits in the output register; one more result
//   can be parked in a hold register, which holds the slave side until it drains.
module arp_responder_with_cache #(
    parameter int ENTRIES       = 16,
    parameter int MIN_FRAME_LEN = 28
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata, low bit up: frame_len[15:0], arp_opcode[31:16],
    // snd_mac[79:32], snd_ip[111:80], tgt_ip[143:112],
    // eth_src_mac[191:144], query_ip[223:192]
    input  logic [223:0]                     i_s_tdata,
    // tuser: req_type
    input  logic                             i_s_tuser,
    // master result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata, low bit up: send_frame[0], frame_opcode[2:1],
    // frame_dest_mac[50:3], frame_target_mac[98:51], frame_tgt_ip[130:99],
    // lookup_hit[131], lookup_mac[179:132], status[182:180], zero pad[183]
    output logic [183:0]                     o_m_tdata,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [arpc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [arpc_pkg::MAC_W-1:0]       i_cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_HOLD   = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [arpc_pkg::IP_W-1:0]  r_own_ip;
    logic [arpc_pkg::MAC_W-1:0] r_own_mac;

    // request held while its search runs
    logic                       r_is_lookup, n_is_lookup;
    logic                       r_is_arp_req, n_is_arp_req;
    logic [arpc_pkg::IP_W-1:0]  r_s_ip, n_s_ip;
    logic [arpc_pkg::MAC_W-1:0] r_s_mac, n_s_mac;
    logic [arpc_pkg::MAC_W-1:0] r_e_src, n_e_src;
    logic [arpc_pkg::IP_W-1:0]  r_q_ip, n_q_ip;

    arpc_pkg::t_probe           r_head, n_head;
    arpc_pkg::t_probe           w_link [ENTRIES+1];

    logic                       r_out_valid, n_out_valid;
    arpc_pkg::t_result          r_out, n_out;
    arpc_pkg::t_result          r_hold, n_hold;
    arpc_pkg::t_result          w_res;
    logic                       w_res_valid;
    logic                       w_out_free;

    // unpacked request fields
    logic [15:0]                w_frame_len;
    logic [15:0]                w_opcode;
    logic [arpc_pkg::MAC_W-1:0] w_snd_mac;
    logic [arpc_pkg::IP_W-1:0]  w_snd_ip;
    logic [arpc_pkg::IP_W-1:0]  w_tgt_ip;
    logic [arpc_pkg::MAC_W-1:0] w_eth_src;
    logic [arpc_pkg::IP_W-1:0]  w_query_ip;

    assign w_frame_len  = i_s_tdata[15:0];
    assign w_opcode     = i_s_tdata[31:16];
    assign w_snd_mac    = i_s_tdata[79:32];
    assign w_snd_ip     = i_s_tdata[111:80];
    assign w_tgt_ip     = i_s_tdata[143:112];
    assign w_eth_src    = i_s_tdata[191:144];
    assign w_query_ip   = i_s_tdata[223:192];

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_m_tready;

    // row of cache cells; the head register feeds the first cell
    assign w_link[0] = r_head;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_link[g]),
            .o_probe (w_link[g+1])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_is_lookup  = r_is_lookup;
        n_is_arp_req = r_is_arp_req;
        n_s_ip       = r_s_ip;
        n_s_mac      = r_s_mac;
        n_e_src      = r_e_src;
        n_q_ip       = r_q_ip;
        n_head       = '0;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_hold       = r_hold;
        w_res        = '0;
        w_res_valid  = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_is_lookup  = i_s_tuser;
                    n_is_arp_req = (w_opcode == arpc_pkg::OP_REQUEST);
                    n_s_ip       = w_snd_ip;
                    n_s_mac      = w_snd_mac;
                    n_e_src      = w_eth_src;
                    n_q_ip       = w_query_ip;
                    if (i_s_tuser) begin
                        n_head.act  = 1'b1;
                        n_head.kind = arpc_pkg::KIND_SEARCH;
                        n_head.ip   = w_query_ip;
                        n_state     = S_SEARCH;
                    end else if (w_frame_len < 16'(MIN_FRAME_LEN)) begin
                        w_res.status = arpc_pkg::ST_TOO_SHORT;
                        w_res_valid  = 1'b1;
                    end else if (w_tgt_ip != r_own_ip) begin
                        w_res.status = arpc_pkg::ST_NOT_US;
                        w_res_valid  = 1'b1;
                    end else if ((w_opcode != arpc_pkg::OP_REQUEST)
                                 && (w_opcode != arpc_pkg::OP_REPLY)) begin
                        w_res.status = arpc_pkg::ST_BAD_OP;
                        w_res_valid  = 1'b1;
                    end else begin
                        n_head.act  = 1'b1;
                        n_head.kind = arpc_pkg::KIND_SEARCH;
                        n_head.ip   = w_snd_ip;
                        n_state     = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // wait for our search token; an earlier write token may pass first
                if (w_link[ENTRIES].act && (w_link[ENTRIES].kind == arpc_pkg::KIND_SEARCH)) begin
                    w_res_valid = 1'b1;
                    if (r_is_lookup) begin
                        if (w_link[ENTRIES].hit) begin
                            w_res.lookup_hit = 1'b1;
                            w_res.lookup_mac = w_link[ENTRIES].mac;
                        end else begin
                            w_res.send_frame     = 1'b1;
                            w_res.frame_opcode   = arpc_pkg::FOP_REQUEST;
                            w_res.frame_dest_mac = arpc_pkg::MAC_BROADCAST;
                            w_res.frame_tgt_ip   = r_q_ip;
                        end
                    end else begin
                        if (r_is_arp_req) begin
                            w_res.send_frame       = 1'b1;
                            w_res.frame_opcode     = arpc_pkg::FOP_REPLY;
                            w_res.frame_dest_mac   = r_e_src;
                            w_res.frame_target_mac = r_e_src;
                            w_res.frame_tgt_ip     = r_s_ip;
                        end
                        if (w_link[ENTRIES].hit || w_link[ENTRIES].free) begin
                            // launch the learn token: update in place or fill
                            n_head.act  = 1'b1;
                            n_head.kind = arpc_pkg::KIND_WRITE;
                            n_head.ip   = r_s_ip;
                            n_head.mac  = r_s_mac;
                            n_head.hit  = w_link[ENTRIES].hit;
                        end else begin
                            w_res.status = arpc_pkg::ST_FULL;
                        end
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out       = r_hold;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // deliver the result, or park it while the receiver stalls
        if (w_res_valid) begin
            if (w_out_free) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_hold  = w_res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head.act  <= 1'b0;
            r_out_valid <= 1'b0;
            r_own_ip    <= '0;
            r_own_mac   <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    arpc_pkg::REG_OWN_IP:  r_own_ip  <= i_cfg_data[arpc_pkg::IP_W-1:0];
                    arpc_pkg::REG_OWN_MAC: r_own_mac <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_is_lookup  <= n_is_lookup;
        r_is_arp_req <= n_is_arp_req;
        r_s_ip       <= n_s_ip;
        r_s_mac      <= n_s_mac;
        r_e_src      <= n_e_src;
        r_q_ip       <= n_q_ip;
        r_out        <= n_out;
        r_hold       <= n_hold;
    end

    // own_mac goes into the sender field of the frame built downstream;
    // the result carries only the fields that vary per request
    logic w_own_mac_unused;
    assign w_own_mac_unused = ^r_own_mac;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {w_own_mac_unused & 1'b0, r_out};

endmodule
